/* hdl/rcrp_pkg.sv */
// Shared constants and arithmetic helpers for the rational circle revolver.
// No dependencies; imported by the channel interfaces and the top level.
package rcrp_pkg;

    // Fixed-point format of all coordinates
    localparam int FRAC_BITS = 16;
    localparam int W_WIDTH   = 31;
    localparam int C_WIDTH   = 32;
    localparam int IDX_WIDTH = 4;

    // Circle layout: nine points, index 8 closes the run
    localparam int POINTS_PER_CIRCLE = 9;
    localparam logic [IDX_WIDTH-1:0] LAST_INDEX = IDX_WIDTH'(POINTS_PER_CIRCLE - 1);

    // Unity weight used when the input is treated as non-rational
    localparam logic [W_WIDTH-1:0] WEIGHT_ONE = W_WIDTH'(1) << FRAC_BITS;

    // sin45 as unsigned Q2.30, and the rounding offset for the Q30 product
    localparam int SIN_FRAC = 30;
    localparam logic signed [63:0] SIN45_Q30 = 64'sd759250125;
    localparam logic signed [63:0] SIN_HALF  = 64'sd1 <<< (SIN_FRAC - 1);

    typedef logic signed [C_WIDTH:0]   t_wide;   // exact x+y / x-y
    typedef logic signed [C_WIDTH+1:0] t_sel;    // selected value before saturation

    // v * sin45, round to nearest with ties toward +inf
    function automatic t_wide mul_sin45(input t_wide v);
        logic signed [63:0] p;
        p = 64'(v) * SIN45_Q30 + SIN_HALF;
        return p[SIN_FRAC+C_WIDTH:SIN_FRAC];
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [C_WIDTH-1:0] sat32(input t_sel v);
        logic signed [C_WIDTH-1:0] r;
        if (v > t_sel'({1'b0, {(C_WIDTH-1){1'b1}}})) begin
            r = {1'b0, {(C_WIDTH-1){1'b1}}};
        end else if (v < -t_sel'({1'b1, {(C_WIDTH-1){1'b0}}})) begin
            r = {1'b1, {(C_WIDTH-1){1'b0}}};
        end else begin
            r = v[C_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/rcrp_in_if.sv */
// Input channel: one homogeneous control point per beat, valid/ready.
// Depends on rcrp_pkg for field widths.
interface rcrp_in_if
    import rcrp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [W_WIDTH-1:0]         weight;
    logic signed [C_WIDTH-1:0]  x_coord;
    logic signed [C_WIDTH-1:0]  y_coord;
    logic signed [C_WIDTH-1:0]  z_coord;

    modport source (output valid, weight, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, weight, x_coord, y_coord, z_coord, output ready);
endinterface

/* hdl/rcrp_out_if.sv */
// Output channel: one circle control point per beat, valid/ready.
// Depends on rcrp_pkg for field widths.
interface rcrp_out_if
    import rcrp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [IDX_WIDTH-1:0]       circle_index;
    logic [W_WIDTH-1:0]         out_weight;
    logic signed [C_WIDTH-1:0]  out_x;
    logic signed [C_WIDTH-1:0]  out_y;
    logic signed [C_WIDTH-1:0]  out_z;
    logic                       last_point;

    modport source (output valid, circle_index, out_weight, out_x, out_y, out_z, last_point,
                    input ready);
    modport sink   (input valid, circle_index, out_weight, out_x, out_y, out_z, last_point,
                    output ready);
endinterface

/* hdl/rational_circle_revolve_points.sv */
// Top level: revolves one control point into the nine-point rational circle about Z.
// Depends on rcrp_pkg, rcrp_in_if and rcrp_out_if.
//
// Usage:
//   i_pnt carries one homogeneous point (weight, x, y, z) per beat; o_pnt
//   returns nine beats per input, circle_index 0..8, last_point set on 8.
//   i_cfg_we/i_cfg_wdata write rational_input (reset 1); when 0 the weight
//   is replaced by 1.0. Write it only while the block is idle.
// Pipeline: input register, product register (four constant multiplies by
//   sin45, rounded), then an emit counter that selects and saturates each
//   point into the output register.
// Order: the first beat passes the input, product and output registers in turn.
// Throughput: nine output beats per input, one output beat per cycle while
//   o_pnt.ready stays high; the next input is taken and its products formed
//   while the current nine points are still being sent.
// Reset: clears all valid flags and the emit counter, sets rational_input.
// Stall: when o_pnt.ready is low the output register holds its beat and the
//   stages behind it fill, then i_pnt.ready drops.
module rational_circle_revolve_points
    import rcrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    rcrp_in_if.sink       i_pnt,
    rcrp_out_if.source    o_pnt
);

    // Configuration
    logic r_rational;

    // Stage 1: held point
    logic                      r_v1;
    logic [W_WIDTH-1:0]        r_w1;
    logic signed [C_WIDTH-1:0] r_x1, r_y1, r_z1;

    // Stage 2: products and pass-through values
    logic                      r_v2;
    logic [W_WIDTH-1:0]        r_w2, r_ws;
    logic signed [C_WIDTH-1:0] r_x2, r_y2, r_z2, r_zs;
    t_wide                     r_sum, r_dif;
    logic [IDX_WIDTH-1:0]      r_cnt;

    // Output register
    logic                      r_ov;
    logic [IDX_WIDTH-1:0]      r_oidx;
    logic [W_WIDTH-1:0]        r_ow;
    logic signed [C_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic                      r_olast;

    logic   out_load, s2_free, s1_adv, in_take;
    t_wide  s_sum, s_dif, s_wp, s_zp;
    t_sel   n_sx, n_sy;
    logic [W_WIDTH-1:0]        n_ow;
    logic signed [C_WIDTH-1:0] n_oz;

    // Flow control
    assign out_load = r_v2 && (!r_ov || o_pnt.ready);
    assign s2_free  = !r_v2 || (out_load && (r_cnt == LAST_INDEX));
    assign s1_adv   = r_v1 && s2_free;
    assign i_pnt.ready = !r_v1 || s2_free;
    assign in_take  = i_pnt.valid && i_pnt.ready;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rational <= 1'b1;
        end else if (i_cfg_we) begin
            r_rational <= i_cfg_wdata;
        end
    end

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_take) begin
            r_v1 <= 1'b1;
        end else if (s1_adv) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_w1 <= r_rational ? i_pnt.weight : WEIGHT_ONE;
            r_x1 <= i_pnt.x_coord;
            r_y1 <= i_pnt.y_coord;
            r_z1 <= i_pnt.z_coord;
        end
    end

    // Scaled terms: sum/difference and the sin45 products
    assign s_sum = mul_sin45(t_wide'(r_x1) + t_wide'(r_y1));
    assign s_dif = mul_sin45(t_wide'(r_x1) - t_wide'(r_y1));
    assign s_wp  = mul_sin45(t_wide'({2'b00, r_w1}));
    assign s_zp  = mul_sin45(t_wide'(r_z1));

    // Stage 2 valid and emit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (s1_adv) begin
                r_v2 <= 1'b1;
            end else if (s2_free) begin
                r_v2 <= 1'b0;
            end
            if (out_load) begin
                r_cnt <= (r_cnt == LAST_INDEX) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_w2  <= r_w1;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_z2  <= r_z1;
            r_sum <= s_sum;
            r_dif <= s_dif;
            r_ws  <= s_wp[W_WIDTH-1:0];
            r_zs  <= s_zp[C_WIDTH-1:0];
        end
    end

    // Point selection by circle index
    always_comb begin
        case (r_cnt)
            4'd1: begin n_sx = t_sel'(r_dif);  n_sy = t_sel'(r_sum);  end
            4'd2: begin n_sx = -t_sel'(r_y2);  n_sy = t_sel'(r_x2);   end
            4'd3: begin n_sx = -t_sel'(r_sum); n_sy = t_sel'(r_dif);  end
            4'd4: begin n_sx = -t_sel'(r_x2);  n_sy = -t_sel'(r_y2);  end
            4'd5: begin n_sx = -t_sel'(r_dif); n_sy = -t_sel'(r_sum); end
            4'd6: begin n_sx = t_sel'(r_y2);   n_sy = -t_sel'(r_x2);  end
            4'd7: begin n_sx = t_sel'(r_sum);  n_sy = -t_sel'(r_dif); end
            default: begin n_sx = t_sel'(r_x2); n_sy = t_sel'(r_y2); end
        endcase
        n_ow = r_cnt[0] ? r_ws : r_w2;
        n_oz = r_cnt[0] ? r_zs : r_z2;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_pnt.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oidx  <= r_cnt;
            r_ow    <= n_ow;
            r_ox    <= sat32(n_sx);
            r_oy    <= sat32(n_sy);
            r_oz    <= n_oz;
            r_olast <= (r_cnt == LAST_INDEX);
        end
    end

    assign o_pnt.valid        = r_ov;
    assign o_pnt.circle_index = r_oidx;
    assign o_pnt.out_weight   = r_ow;
    assign o_pnt.out_x        = r_ox;
    assign o_pnt.out_y        = r_oy;
    assign o_pnt.out_z        = r_oz;
    assign o_pnt.last_point   = r_olast;

endmodule
